### sv/lifetime_memory_peak_tracker_core_macros.svh
// assertion helpers, clocked on clock and disabled while reset is high
`ifndef LIFETIME_MEMORY_PEAK_TRACKER_CORE_MACROS_SVH
`define LIFETIME_MEMORY_PEAK_TRACKER_CORE_MACROS_SVH

// antecedent holds in the same cycle as the consequent
`define LMPT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent holds in the cycle after the antecedent
`define LMPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lmpt_pkg.sv
package lmpt_pkg;

   localparam int MAX_LIFE    = 128;
   localparam int RING_BITS   = $clog2(MAX_LIFE + 1);
   localparam int RING_DEPTH  = 1 << RING_BITS;
   localparam int LIFE_W      = 8;
   localparam int SIZE_W      = 32;
   localparam int COUNT_W     = 48;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = QUEUE_PTR_W + 1;
   localparam int OUT_DEPTH   = 4;
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = OUT_PTR_W + 1;
   localparam int LOAD_W      = OUT_CNT_W + 1;

   localparam logic [COUNT_W-1:0] SAT_MAX = '1;

   typedef logic [RING_BITS-1:0] slot_type;
   typedef logic [COUNT_W-1:0]   count_type;

   typedef struct packed {
      slot_type            slot;
      slot_type            target;
      logic [SIZE_W-1:0]   size;
   } work_type;

   typedef struct packed {
      count_type current;
      count_type peak;
      count_type total;
      count_type releases;
   } result_type;

   function automatic count_type sat_add(count_type a, count_type b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? SAT_MAX : s[COUNT_W-1:0];
   endfunction

endpackage

### sv/lmpt_ram.sv
module lmpt_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/lmpt_front.sv
module lmpt_front import lmpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [LIFE_W-1:0] req_lifetime_steps,
   input  logic [SIZE_W-1:0] req_size_bytes,
   input  logic              head_pop,
   output logic              head_valid,
   output work_type          head
);

   work_type                 entry_ff [QUEUE_DEPTH];
   work_type                 entry_in;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   slot_type                 step_ff, step_in;
   logic [LIFE_W-1:0]        life;
   logic                     push;

   // lifetime clamped to 1..MAX_LIFE
   always_comb begin
      life = req_lifetime_steps;
      if (req_lifetime_steps == '0) begin
         life = LIFE_W'(1);
      end else if (32'(req_lifetime_steps) > MAX_LIFE) begin
         life = LIFE_W'(MAX_LIFE);
      end
   end

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid & req_ready;

   always_comb begin
      entry_in.slot   = step_ff;
      entry_in.target = RING_BITS'(32'(step_ff) + 32'(life));
      entry_in.size   = req_size_bytes;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      step_in   = step_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QUEUE_PTR_W'(1);
         step_in   = step_ff + RING_BITS'(1);
      end
      if (head_pop) begin
         rd_ptr_in = rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      case ({push, head_pop})
         2'b10:   count_in = count_ff + QUEUE_CNT_W'(1);
         2'b01:   count_in = count_ff - QUEUE_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         step_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         step_ff   <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

### sv/lmpt_out.sv
module lmpt_out import lmpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  result_type           push_data,
   output logic [OUT_CNT_W-1:0] count,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [COUNT_W-1:0]   rsp_current_bytes,
   output logic [COUNT_W-1:0]   rsp_peak_bytes,
   output logic [COUNT_W-1:0]   rsp_total_bytes,
   output logic [COUNT_W-1:0]   rsp_release_events
);

   result_type               entry_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [OUT_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OUT_CNT_W-1:0]     count_ff, count_in;
   logic                     pop;
   result_type               head;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid & rsp_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + OUT_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + OUT_PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + OUT_CNT_W'(1);
         2'b01:   count_in = count_ff - OUT_CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head               = entry_ff[rd_ptr_ff];
   assign count              = count_ff;
   assign rsp_current_bytes  = head.current;
   assign rsp_peak_bytes     = head.peak;
   assign rsp_total_bytes    = head.total;
   assign rsp_release_events = head.releases;

endmodule

### sv/lmpt_back.sv
`include "lifetime_memory_peak_tracker_core_macros.svh"

module lmpt_back import lmpt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic                 csr_write_data,
   input  logic                 head_valid,
   input  work_type             head,
   output logic                 head_pop,
   input  logic [OUT_CNT_W-1:0] out_count,
   output logic                 out_push,
   output result_type           out_data
);

   logic                    retain_ff;
   logic [RING_DEPTH-1:0]   valid_ff, valid_in;

   logic                    t_v_ff, w_v_ff, p_v_ff;
   work_type                t_work_ff, w_work_ff;
   logic                    w_due_nz_ff, due_nz_in;
   count_type               live_rel_ff, live_rel_in;

   logic                    fwd_v_ff;
   slot_type                fwd_addr_ff;
   count_type               fwd_data_ff;

   count_type               live_ff, live_in;
   count_type               peak_ff, peak_in;
   count_type               total_ff, total_in;
   count_type               rel_ff, rel_in;

   logic [LOAD_W-1:0]       load;
   slot_type                rd_addr;
   count_type               rd_data;
   logic                    wr_en;
   count_type               due_raw, due, tgt_old, tgt_sum, size_ext;

   // slot read and target read share the ring read port
   assign load = LOAD_W'(out_count) + LOAD_W'(t_v_ff) + LOAD_W'(w_v_ff) + LOAD_W'(p_v_ff);
   assign head_pop = head_valid && !t_v_ff && (load < LOAD_W'(OUT_DEPTH));

   assign rd_addr = t_v_ff ? t_work_ff.target : head.slot;
   assign wr_en   = w_v_ff && !retain_ff;

   lmpt_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (w_work_ff.target),
      .wr_data (tgt_sum),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // slot stage: release due bytes
   always_comb begin
      due_raw = (fwd_v_ff && (fwd_addr_ff == t_work_ff.slot)) ? fwd_data_ff : rd_data;
      due     = valid_ff[t_work_ff.slot] ? due_raw : '0;
      if (retain_ff) begin
         live_rel_in = live_ff;
         due_nz_in   = 1'b0;
      end else begin
         live_rel_in = (due >= live_ff) ? '0 : live_ff - due;
         due_nz_in   = (due != '0);
      end
   end

   // target stage: schedule release and update counts
   always_comb begin
      size_ext = COUNT_W'(w_work_ff.size);
      tgt_old  = valid_ff[w_work_ff.target] ? rd_data : '0;
      tgt_sum  = sat_add(tgt_old, size_ext);
      live_in  = live_ff;
      total_in = total_ff;
      rel_in   = rel_ff;
      if (w_v_ff) begin
         live_in  = sat_add(live_rel_ff, size_ext);
         total_in = sat_add(total_ff, size_ext);
         if (w_due_nz_ff) begin
            rel_in = sat_add(rel_ff, COUNT_W'(1));
         end
      end
   end

   // peak stage
   always_comb begin
      peak_in = (live_ff > peak_ff) ? live_ff : peak_ff;
      out_data.current  = live_ff;
      out_data.peak     = peak_in;
      out_data.total    = total_ff;
      out_data.releases = rel_ff;
   end

   assign out_push = p_v_ff;

   always_comb begin
      valid_in = valid_ff;
      if (t_v_ff) begin
         valid_in[t_work_ff.slot] = 1'b0;
      end
      if (wr_en) begin
         valid_in[w_work_ff.target] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         retain_ff <= 1'b0;
         valid_ff  <= '0;
         t_v_ff    <= 1'b0;
         w_v_ff    <= 1'b0;
         p_v_ff    <= 1'b0;
         fwd_v_ff  <= 1'b0;
         live_ff   <= '0;
         peak_ff   <= '0;
         total_ff  <= '0;
         rel_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            retain_ff <= csr_write_data;
         end
         valid_ff <= valid_in;
         t_v_ff   <= head_pop;
         w_v_ff   <= t_v_ff;
         p_v_ff   <= w_v_ff;
         fwd_v_ff <= wr_en;
         live_ff  <= live_in;
         total_ff <= total_in;
         rel_ff   <= rel_in;
         if (p_v_ff) begin
            peak_ff <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         t_work_ff <= head;
      end
      if (t_v_ff) begin
         w_work_ff   <= t_work_ff;
         live_rel_ff <= live_rel_in;
         w_due_nz_ff <= due_nz_in;
      end
      fwd_addr_ff <= w_work_ff.target;
      fwd_data_ff <= tgt_sum;
   end

   `LMPT_ASSERT_IMPLY(a_port_free, t_v_ff, !head_pop, "ring read port double booked")
   `LMPT_ASSERT_IMPLY(a_target_apart, t_v_ff, t_work_ff.target != t_work_ff.slot, "target hits own slot")
   `LMPT_ASSERT_IMPLY(a_out_room, p_v_ff, out_count < OUT_CNT_W'(OUT_DEPTH), "response queue overrun")
   `LMPT_ASSERT_NEXT(a_stage_order, t_v_ff, w_v_ff && !t_v_ff, "target stage did not follow slot stage")

endmodule

### sv/lifetime_memory_peak_tracker_core.sv
// Tracks live, peak and total allocated bytes for a stream of buffers, each
// given with a lifetime in steps (clamped to 1..128) and a size. Every request
// is one step and produces exactly one response. A front end takes requests
// into a two-entry queue; the back end works through a 256-entry release ring
// whose single read port is used twice per request (due slot, then release
// target), so a request enters the ring only once the previous one has left
// the slot stage, then passes the target and peak stages. A four-entry response
// queue lets requests keep flowing while responses are held off. Ring entries
// carry valid bits cleared by reset, so the block is ready in the first cycle
// after reset. All counts saturate at 2^48-1. The retain-all mode bit is written
// through csr_write_enable; the user must write it only while idle, and the
// block does not enforce this. In that mode nothing is scheduled or released.
module lifetime_memory_peak_tracker_core import lmpt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [LIFE_W-1:0] req_lifetime_steps,
   input  logic [SIZE_W-1:0] req_size_bytes,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [COUNT_W-1:0] rsp_current_bytes,
   output logic [COUNT_W-1:0] rsp_peak_bytes,
   output logic [COUNT_W-1:0] rsp_total_bytes,
   output logic [COUNT_W-1:0] rsp_release_events
);

   logic                 head_valid;
   logic                 head_pop;
   work_type             head;
   logic [OUT_CNT_W-1:0] out_count;
   logic                 out_push;
   result_type           out_data;

   lmpt_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_lifetime_steps (req_lifetime_steps),
      .req_size_bytes     (req_size_bytes),
      .head_pop           (head_pop),
      .head_valid         (head_valid),
      .head               (head)
   );

   lmpt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head             (head),
      .head_pop         (head_pop),
      .out_count        (out_count),
      .out_push         (out_push),
      .out_data         (out_data)
   );

   lmpt_out u_out (
      .clock              (clock),
      .reset              (reset),
      .push               (out_push),
      .push_data          (out_data),
      .count              (out_count),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_current_bytes  (rsp_current_bytes),
      .rsp_peak_bytes     (rsp_peak_bytes),
      .rsp_total_bytes    (rsp_total_bytes),
      .rsp_release_events (rsp_release_events)
   );

endmodule

### dv/lifetime_memory_peak_tracker_core_monitor.sv
`timescale 1ns / 100ps
module lmpt_usage_monitor import lmpt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_write_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [LIFE_W-1:0]  req_lifetime_steps,
   input  logic [SIZE_W-1:0]  req_size_bytes,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [COUNT_W-1:0] rsp_current_bytes,
   input  logic [COUNT_W-1:0] rsp_peak_bytes,
   input  logic [COUNT_W-1:0] rsp_total_bytes,
   input  logic [COUNT_W-1:0] rsp_release_events,
   output int                 pending_results,
   output int                 failures
);

   count_type  release_due [RING_DEPTH];
   slot_type   step_ptr;
   count_type  live_now;
   count_type  peak_seen;
   count_type  alloc_sum;
   count_type  release_count;
   logic       keep_all;
   result_type expected_usage [$];
   int         mismatch_count = 0;

   function automatic count_type add_capped(count_type a, count_type b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[COUNT_W])
         return '1;
      return s[COUNT_W-1:0];
   endfunction

   function automatic void predict_alloc(logic [LIFE_W-1:0] life_raw,
                                         logic [SIZE_W-1:0] size);
      slot_type          slot_now;
      slot_type          slot_free;
      count_type         due;
      count_type         size_wide;
      logic [LIFE_W-1:0] life;
      result_type        usage;
      slot_now = step_ptr;
      due = release_due[slot_now];
      life = life_raw;
      size_wide = count_type'(size);
      if (life == 0)
         life = LIFE_W'(1);
      if (life > MAX_LIFE)
         life = LIFE_W'(MAX_LIFE);
      release_due[slot_now] = '0;
      if (!keep_all) begin
         live_now = (due >= live_now) ? '0 : live_now - due;
         if (due != 0)
            release_count = add_capped(release_count, count_type'(1));
      end
      live_now = add_capped(live_now, size_wide);
      alloc_sum = add_capped(alloc_sum, size_wide);
      if (!keep_all) begin
         slot_free = slot_now + slot_type'(life);
         release_due[slot_free] = add_capped(release_due[slot_free], size_wide);
      end
      if (live_now > peak_seen)
         peak_seen = live_now;
      step_ptr = slot_now + 1'b1;
      usage.current = live_now;
      usage.peak = peak_seen;
      usage.total = alloc_sum;
      usage.releases = release_count;
      expected_usage.push_back(usage);
   endfunction

   function automatic void flag_mismatch(string what, result_type want);
      if (mismatch_count < 10)
         $display("%t usage_monitor: %s: exp cur=%h peak=%h total=%h rel=%h",
                  $time, what, want.current, want.peak, want.total, want.releases,
                  " got cur=%h peak=%h total=%h rel=%h",
                  rsp_current_bytes, rsp_peak_bytes, rsp_total_bytes,
                  rsp_release_events);
      mismatch_count++;
   endfunction

   function automatic void check_usage();
      result_type want;
      if (expected_usage.size() == 0) begin
         flag_mismatch("response with no request outstanding", want);
         return;
      end
      want = expected_usage.pop_front();
      if (rsp_current_bytes !== want.current || rsp_peak_bytes !== want.peak ||
          rsp_total_bytes !== want.total || rsp_release_events !== want.releases)
         flag_mismatch("usage mismatch", want);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_DEPTH; i++)
            release_due[i] = '0;
         step_ptr = '0;
         live_now = '0;
         peak_seen = '0;
         alloc_sum = '0;
         release_count = '0;
         keep_all = 1'b0;
      end else begin
         if (csr_write_enable)
            keep_all = csr_write_data;
         if (req_valid && req_ready)
            predict_alloc(req_lifetime_steps, req_size_bytes);
         if (rsp_valid && rsp_ready)
            check_usage();
      end
      pending_results <= expected_usage.size();
      failures <= mismatch_count;
   end

endmodule

### dv/lifetime_memory_peak_tracker_core_tb.sv
`timescale 1ns / 100ps
module lifetime_memory_peak_tracker_core_tb;
   import lmpt_pkg::*;

   localparam int LONG_HOLD  = 80;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic               csr_write_data = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [LIFE_W-1:0]  req_lifetime_steps = '0;
   logic [SIZE_W-1:0]  req_size_bytes = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [COUNT_W-1:0] rsp_current_bytes;
   logic [COUNT_W-1:0] rsp_peak_bytes;
   logic [COUNT_W-1:0] rsp_total_bytes;
   logic [COUNT_W-1:0] rsp_release_events;
   int                 pending_results;
   int                 failures;
   bit                 hold_off_req = 1'b0;
   int                 burst_left = 0;

   always #10 clock = ~clock;

   lifetime_memory_peak_tracker_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_lifetime_steps (req_lifetime_steps),
      .req_size_bytes     (req_size_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_current_bytes  (rsp_current_bytes),
      .rsp_peak_bytes     (rsp_peak_bytes),
      .rsp_total_bytes    (rsp_total_bytes),
      .rsp_release_events (rsp_release_events)
   );

   lmpt_usage_monitor usage_monitor (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_lifetime_steps (req_lifetime_steps),
      .req_size_bytes     (req_size_bytes),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_current_bytes  (rsp_current_bytes),
      .rsp_peak_bytes     (rsp_peak_bytes),
      .rsp_total_bytes    (rsp_total_bytes),
      .rsp_release_events (rsp_release_events),
      .pending_results    (pending_results),
      .failures           (failures)
   );

   function automatic logic [LIFE_W-1:0] pick_lifetime();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return LIFE_W'($urandom_range(MAX_LIFE + 1, (1 << LIFE_W) - 1));
         2, 3, 4: return LIFE_W'($urandom_range(1, 8));
         default: return LIFE_W'($urandom_range(1, MAX_LIFE));
      endcase
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return SIZE_W'($urandom_range(1, 4096));
         default: return SIZE_W'($urandom());
      endcase
   endfunction

   task automatic offer_alloc(input logic [LIFE_W-1:0] life,
                              input logic [SIZE_W-1:0] size, input bit gapless);
      int gap;
      req_valid <= 1'b1;
      req_lifetime_steps <= life;
      req_size_bytes <= size;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      if (!gapless) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0)
         @(posedge clock);
   endtask

   task automatic set_retain(input logic value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic run_random(input int count);
      for (int i = 0; i < count; i++)
         offer_alloc(pick_lifetime(), pick_size(), 1'b0);
   endtask

   task automatic run_held_burst(input int count);
      hold_off_req = 1'b1;
      for (int i = 0; i < count; i++)
         offer_alloc(pick_lifetime(), pick_size(), 1'b1);
   endtask

   // response side stalls on its own pattern, with a long hold when asked
   initial begin : rsp_side
      int seg_left;
      int pattern;
      int hold_left;
      seg_left = 0;
      pattern = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (seg_left == 0) begin
               pattern = $urandom_range(0, 3);
               seg_left = $urandom_range(4, 40);
            end
            seg_left--;
            case (pattern)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_retain(1'b0);

      offer_alloc('0, '0, 1'b0);
      offer_alloc(LIFE_W'(1), '1, 1'b0);
      offer_alloc(LIFE_W'(1), SIZE_W'(1), 1'b0);
      offer_alloc(LIFE_W'(MAX_LIFE), '1, 1'b0);
      offer_alloc(LIFE_W'(MAX_LIFE + 1), 32'h1234_5678, 1'b0);
      offer_alloc('1, 32'h8000_0001, 1'b0);
      offer_alloc(LIFE_W'(2), 32'hFFFF_0000, 1'b0);
      offer_alloc(LIFE_W'(3), 32'h0000_FFFF, 1'b0);
      offer_alloc(LIFE_W'(1), 32'hAAAA_AAAA, 1'b0);
      offer_alloc(LIFE_W'(1), 32'h5555_5555, 1'b0);
      offer_alloc(LIFE_W'(5), SIZE_W'(100), 1'b0);
      offer_alloc(LIFE_W'(5), SIZE_W'(200), 1'b0);
      offer_alloc(LIFE_W'(5), SIZE_W'(300), 1'b0);

      // scheduled releases fall due while everything is retained
      set_retain(1'b1);
      for (int i = 0; i < 8; i++)
         offer_alloc(LIFE_W'(1), SIZE_W'(7), 1'b0);
      set_retain(1'b0);
      for (int i = 0; i < 4; i++)
         offer_alloc(LIFE_W'(1), SIZE_W'(9), 1'b0);

      run_random(200);
      run_held_burst(40);
      run_random(200);

      set_retain(1'b1);
      run_random(100);
      run_held_burst(30);
      run_random(50);

      set_retain(1'b0);
      run_random(165);
      run_random(40);

      drain_results();
      repeat (12) @(posedge clock);
      if (failures == 0 && pending_results == 0)
         $display("lifetime_memory_peak_tracker_core_tb: done, clean");
      else
         $display("lifetime_memory_peak_tracker_core_tb: done, errors");
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("lifetime_memory_peak_tracker_core_tb: done, errors");
      $finish;
   end

endmodule
